// ----- rtl/msort_pkg.sv -----
// shared types and constants for the merge sorter
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic                     truncated;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic merge;
        logic emit;
        logic emit_out;
    } dp_cmd_t;

    typedef struct packed {
        logic accept_last;
        logic single;
        logic pass_done;
        logic sort_done;
        logic out_free;
        logic emit_last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/msort_ram.sv -----
// generic memory, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/msort_ctrl.sv -----
// sequencer for load, merge passes and emit
`timescale 1ns / 1ps
`default_nettype none

module msort_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire msort_pkg::dp_sts_t sts,
    output msort_pkg::dp_cmd_t     cmd
);

    import msort_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_MERGE,
        ST_EMIT_ADDR,
        ST_EMIT_DATA
    } state_t;

    state_t  state_reg, state_next;
    dp_cmd_t cmd_reg, cmd_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (sts.accept_last) begin
                    state_next = sts.single ? ST_EMIT_ADDR : ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (sts.sort_done) begin
                    state_next = ST_EMIT_ADDR;
                end else if (sts.pass_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_EMIT_ADDR: begin
                state_next = ST_EMIT_DATA;
            end
            ST_EMIT_DATA: begin
                if (sts.out_free) begin
                    state_next = sts.emit_last ? ST_LOAD : ST_EMIT_ADDR;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd_next.load     = (state_next == ST_LOAD);
        cmd_next.merge    = (state_next == ST_MERGE);
        cmd_next.emit     = (state_next == ST_EMIT_ADDR) || (state_next == ST_EMIT_DATA);
        cmd_next.emit_out = (state_next == ST_EMIT_DATA);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cmd_reg   <= '{load: 1'b1, merge: 1'b0, emit: 1'b0, emit_out: 1'b0};
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign cmd = cmd_reg;

endmodule

`default_nettype wire

// ----- rtl/msort_dp.sv -----
// element stores, merge unit, counters and output register
`timescale 1ns / 1ps
`default_nettype none

module msort_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire msort_pkg::dp_cmd_t  cmd,
    output msort_pkg::dp_sts_t       sts,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire logic                s_valid,
    input  wire msort_pkg::in_item_t s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msort_pkg::out_item_t     m_item
);

    import msort_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic             desc_cfg_reg, desc_cfg_next;
    logic             sort_desc_reg, sort_desc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             trunc_reg, trunc_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_reg, src_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    logic                     accept, has_room, out_free;
    logic [CNT_W-1:0]         n_new, k_inc;
    logic [SUM_W-1:0]         w1, w2, w4;
    logic [DATA_W-1:0]        rd_a0, rd_a1, rd_b0, rd_b1;
    logic signed [DATA_W-1:0] ri, rj, wr_val;
    logic                     i_done, j_done, take_j, before_ji;
    logic                     run_done, pass_done, sort_done;
    logic                     we_a, we_b;
    logic [ADDR_W-1:0]        waddr_a, raddr_0, raddr_1;
    logic [DATA_W-1:0]        wdata_a;

    function automatic logic [CNT_W-1:0] clip_n(input logic [SUM_W-1:0] x,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] nx;
        nx = SUM_W'(n);
        return (x > nx) ? n : x[CNT_W-1:0];
    endfunction

    assign accept   = cmd.load && s_valid;
    assign has_room = (count_reg != CAP_CNT);
    assign out_free = !m_valid_reg || m_ready;
    assign n_new    = has_room ? count_reg + ONE_CNT : count_reg;
    assign k_inc    = k_reg + ONE_CNT;
    assign w1       = SUM_W'(width_reg);
    assign w2       = {1'b0, width_reg, 1'b0};
    assign w4       = {width_reg, 2'b00};

    assign ri        = $signed(src_reg ? rd_b0 : rd_a0);
    assign rj        = $signed(src_reg ? rd_b1 : rd_a1);
    assign i_done    = (i_reg == mid_reg);
    assign j_done    = (j_reg == hi_reg);
    assign before_ji = sort_desc_reg ? (rj > ri) : (rj < ri);
    assign take_j    = i_done || (!j_done && before_ji);
    assign wr_val    = take_j ? rj : ri;
    assign run_done  = cmd.merge && (k_inc == hi_reg);
    assign pass_done = run_done && (hi_reg == n_reg);
    assign sort_done = pass_done && (w2 >= SUM_W'(n_reg));

    always_comb begin
        desc_cfg_next  = cfg_wr_en ? cfg_wr_data : desc_cfg_reg;
        sort_desc_next = sort_desc_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        trunc_next     = trunc_reg;
        n_next         = n_reg;
        width_next     = width_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;

        if (accept) begin
            if (has_room) begin
                count_next = count_reg + ONE_CNT;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_item.last) begin
                count_next     = '0;
                ovf_next       = 1'b0;
                trunc_next     = ovf_reg || !has_room;
                n_next         = n_new;
                sort_desc_next = desc_cfg_reg;
                width_next     = ONE_CNT;
                i_next         = '0;
                k_next         = '0;
                mid_next       = clip_n(SUM_W'(1), n_new);
                j_next         = clip_n(SUM_W'(1), n_new);
                hi_next        = clip_n(SUM_W'(2), n_new);
                src_next       = 1'b0;
            end
        end

        if (cmd.merge) begin
            k_next = k_inc;
            if (take_j) begin
                j_next = j_reg + ONE_CNT;
            end else begin
                i_next = i_reg + ONE_CNT;
            end
            if (pass_done) begin
                src_next   = !src_reg;
                width_next = w2[CNT_W-1:0];
                i_next     = '0;
                k_next     = '0;
                mid_next   = clip_n(w2, n_reg);
                j_next     = clip_n(w2, n_reg);
                hi_next    = clip_n(w4, n_reg);
            end else if (run_done) begin
                i_next   = hi_reg;
                mid_next = clip_n(SUM_W'(hi_reg) + w1, n_reg);
                j_next   = clip_n(SUM_W'(hi_reg) + w1, n_reg);
                hi_next  = clip_n(SUM_W'(hi_reg) + w2, n_reg);
            end
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit_out && out_free) begin
            m_valid_next             = 1'b1;
            m_item_next.sorted_value = ri;
            m_item_next.final_res    = (k_inc == n_reg);
            m_item_next.truncated    = trunc_reg;
            k_next                   = k_inc;
        end
    end

    // store writes: load into element store, merge writes the other bank
    assign we_a    = (accept && has_room) || (cmd.merge && src_reg);
    assign waddr_a = cmd.merge ? k_reg[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
    assign wdata_a = cmd.merge ? wr_val : s_item.value;
    assign we_b    = cmd.merge && !src_reg;
    assign raddr_0 = cmd.emit ? k_reg[ADDR_W-1:0] : i_next[ADDR_W-1:0];
    assign raddr_1 = j_next[ADDR_W-1:0];

    msort_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_element_store (
        .aclk    (aclk),
        .we      (we_a),
        .waddr   (waddr_a),
        .wdata   (wdata_a),
        .raddr_a (raddr_0),
        .raddr_b (raddr_1),
        .rdata_a (rd_a0),
        .rdata_b (rd_a1)
    );

    msort_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_merge_scratch (
        .aclk    (aclk),
        .we      (we_b),
        .waddr   (k_reg[ADDR_W-1:0]),
        .wdata   (wr_val),
        .raddr_a (raddr_0),
        .raddr_b (raddr_1),
        .rdata_a (rd_b0),
        .rdata_b (rd_b1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_cfg_reg <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            desc_cfg_reg <= desc_cfg_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sort_desc_reg <= sort_desc_next;
        trunc_reg     <= trunc_next;
        n_reg         <= n_next;
        width_reg     <= width_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        src_reg       <= src_next;
        m_item_reg    <= m_item_next;
    end

    assign sts.accept_last = accept && s_item.last;
    assign sts.single      = (n_new == ONE_CNT);
    assign sts.pass_done   = pass_done;
    assign sts.sort_done   = sort_done;
    assign sts.out_free    = out_free;
    assign sts.emit_last   = (k_inc == n_reg);

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ----- rtl/merge_sorter_unit.sv -----
// top level of the merge sorter
`timescale 1ns / 1ps
`default_nettype none

// Collects up to 64 signed values, one per accepted item, and after the item
// marked last emits them sorted (ascending, or descending when the register is
// set at the time the last item arrives), the final result marked final_res and
// every result of an overfilled batch marked truncated. Sorting is bottom-up
// merging by a single merge unit that writes one element per cycle, alternating
// between two stores over ceil(log2 n) passes. Each result is emitted by a store
// read, then the output register. No item is taken while a batch is being
// sorted or emitted.
module merge_sorter_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire msort_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output msort_pkg::out_item_t      m_item
);

    import msort_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    msort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    msort_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    assign s_ready = cmd.load;

endmodule

`default_nettype wire

// ----- rtl/msort_checker.sv -----
// port checker for the merge sorter and its bind
`timescale 1ns / 1ps
`default_nettype none

module msort_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire msort_pkg::in_item_t  s_item,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire msort_pkg::out_item_t m_item
);

    import msort_pkg::*;

    // result held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item dropped or changed while stalled");

    // nothing on the result side right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // last item closes the input until the batch is out
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.last |=> !s_ready)
        else $error("input open right after last item");

    // input stays closed while a batch is mid-emission
    a_emit_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.final_res |-> !s_ready)
        else $error("input open during emission");

    // truncated flag is the same across one batch
    a_trunc_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.final_res |=>
            !m_valid || $stable(m_item.truncated))
        else $error("truncated flag changed within a batch");

endmodule

bind merge_sorter_unit msort_checker u_msort_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the merge sorter: sorted batches predicted and compared per result
`timescale 1ns / 1ps

module testbench;
    import msort_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 26;
    localparam int SETTLE       = 16;
    localparam int TAIL_CYCLES  = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 20;

    localparam logic ASCENDING  = 1'b0;
    localparam logic DESCENDING = 1'b1;

    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] EDGE_MIX [7] =
        '{MIN_VAL, MAX_VAL, 0, -1, 1, MAX_VAL, MIN_VAL};

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_item      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_item;

    in_item_t                 pending [$];
    logic signed [DATA_W-1:0] batch_values [$];
    out_item_t                sorted_due [$];
    logic                     batch_spilled = 1'b0;
    logic                     order_sel     = ASCENDING;
    logic                     steady        = 1'b0;

    int items_queued    = 0;
    int items_accepted  = 0;
    int batches_done    = 0;
    int batches_spilled = 0;
    int results_seen    = 0;
    int mismatches      = 0;
    int hold_left       = 0;
    logic hold_done     = 1'b0;

    merge_sorter_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic ahead_of(logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b);
        return (order_sel == DESCENDING) ? (a > b) : (a < b);
    endfunction

    // store the value, and on the closing item sort the batch into expected results
    function automatic void absorb_value(in_item_t it);
        logic signed [DATA_W-1:0] run [$];
        logic signed [DATA_W-1:0] key;
        out_item_t res;
        int i;
        int j;
        if (batch_values.size() < CAPACITY) begin
            batch_values.push_back(it.value);
        end else begin
            batch_spilled = 1'b1;
        end
        if (!it.last) return;
        run = batch_values;
        for (i = 1; i < run.size(); i++) begin
            key = run[i];
            j = i - 1;
            while (j >= 0 && ahead_of(key, run[j])) begin
                run[j + 1] = run[j];
                j--;
            end
            run[j + 1] = key;
        end
        for (i = 0; i < run.size(); i++) begin
            res.sorted_value = run[i];
            res.final_res    = (i == run.size() - 1);
            res.truncated    = batch_spilled;
            sorted_due.push_back(res);
        end
        batches_done++;
        if (batch_spilled) batches_spilled++;
        batch_values.delete();
        batch_spilled = 1'b0;
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        results_seen++;
        if (sorted_due.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("unexpected result: value %0d final %b truncated %b",
                         got.sorted_value, got.final_res, got.truncated);
            mismatches++;
            return;
        end
        want = sorted_due.pop_front();
        if (got.sorted_value !== want.sorted_value || got.final_res !== want.final_res ||
            got.truncated !== want.truncated) begin
            if (mismatches < MAX_REPORTS)
                $display("result %0d: expected %0d/%b/%b, got %0d/%b/%b", results_seen,
                         want.sorted_value, want.final_res, want.truncated,
                         got.sorted_value, got.final_res, got.truncated);
            mismatches++;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2, 3: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_value(s_item);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_item  <= pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_item);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER && pending.size() != 0) begin
                // long output hold so the sorter backs up into its input
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic push_item(logic signed [DATA_W-1:0] v, logic is_last);
        in_item_t it;
        it.value = v;
        it.last  = is_last;
        pending.push_back(it);
        items_queued++;
    endtask

    task automatic queue_batch(int count);
        int k;
        for (k = 0; k < count; k++) push_item(pick_value(), k == count - 1);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (items_accepted != items_queued || sorted_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_order(logic o);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= o;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        order_sel = o;
        @(negedge aclk);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("merge_sorter_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int i;
        int p;
        int n;
        int phase_items;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes and repeats in both orders, and a single-element batch in ascending order
        set_order(ASCENDING);
        for (i = 0; i < 7; i++) push_item(EDGE_MIX[i], i == 6);
        push_item(-7, 1'b1);
        set_order(DESCENDING);
        for (i = 0; i < 7; i++) push_item(EDGE_MIX[i], i == 6);
        push_item(3, 1'b0);
        push_item(-3, 1'b1);

        for (p = 0; p < 5; p++) begin
            set_order((p % 2 == 0) ? DESCENDING : ASCENDING);
            steady = (p == 2);
            phase_items = 0;
            if (p == 0) begin
                // one past capacity, the closing item itself dropped
                queue_batch(CAPACITY + 1);
                phase_items += CAPACITY + 1;
            end
            if (p == 3) begin
                queue_batch(CAPACITY);
                phase_items += CAPACITY;
            end
            if (p == 4) begin
                queue_batch(CAPACITY + 4);
                phase_items += CAPACITY + 4;
            end
            while (phase_items < PHASE_ITEMS) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
                queue_batch(n);
                phase_items += n;
            end
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items in %0d batches (%0d overfilled), %0d results checked",
                 items_accepted, batches_done, batches_spilled, results_seen);
        $display("both sort orders, extreme and repeated values, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && sorted_due.size() == 0) begin
            $display("merge_sorter_unit test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, sorted_due.size());
            $display("merge_sorter_unit test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/msort_pkg.sv
rtl/msort_ram.sv
rtl/msort_ctrl.sv
rtl/msort_dp.sv
rtl/merge_sorter_unit.sv
rtl/msort_checker.sv
verif/testbench.sv
